// File: hw/rtl/dtnp_pkg.sv
// ----------------------------------------------------------------------------
// dtnp_pkg: shared definitions for the decimal text number parser
// Character codes, limits, configuration register indexes and the structs
// that pass between the pipeline stages.
// ----------------------------------------------------------------------------
package dtnp_pkg;

    // ASCII codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam int MANT_WIDTH  = 64;
    localparam int PROD_WIDTH  = MANT_WIDTH + 4;
    localparam int FRAC_WIDTH  = 5;
    localparam int COUNT_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 1;

    localparam logic [MANT_WIDTH-1:0] MANT_LIMIT = {1'b0, {(MANT_WIDTH-1){1'b1}}};
    localparam logic [FRAC_WIDTH-1:0] MAX_FRACTION_DIGITS = 5'd18;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_REAL_MODE   = 1'b0,
        REG_GOBBLE_MODE = 1'b1
    } cfg_reg_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // One input character as held in the input register
    typedef struct packed {
        logic [7:0] text_char;
        logic       string_end;
    } char_item_t;

    // Finished parse before sign handling
    typedef struct packed {
        logic                  parse_ok;
        logic                  real_mode;
        logic                  is_negative;
        logic [MANT_WIDTH-1:0] magnitude;
        logic [FRAC_WIDTH-1:0] fraction_digits;
        count_t                chars_consumed;
        logic                  hit_string_end;
    } raw_result_t;

endpackage

// File: hw/rtl/dtnp_char_if.sv
// ----------------------------------------------------------------------------
// dtnp_char_if: character stream channel
// Valid/ready channel carrying one text character and its end-of-string mark.
// ----------------------------------------------------------------------------
interface dtnp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       string_end;

    modport source (output valid, output text_char, output string_end, input ready);
    modport sink   (input valid, input text_char, input string_end, output ready);
endinterface

// File: hw/rtl/dtnp_result_if.sv
// ----------------------------------------------------------------------------
// dtnp_result_if: parse result channel
// Valid/ready channel carrying one parsed number and its status.
// ----------------------------------------------------------------------------
interface dtnp_result_if;
    logic               valid;
    logic               ready;
    logic               parse_ok;
    logic signed [63:0] mantissa;
    logic [4:0]         fraction_digits;
    logic [15:0]        chars_consumed;
    logic               hit_string_end;

    modport source (
        output valid, output parse_ok, output mantissa, output fraction_digits,
        output chars_consumed, output hit_string_end, input ready
    );
    modport sink (
        input valid, input parse_ok, input mantissa, input fraction_digits,
        input chars_consumed, input hit_string_end, output ready
    );
endinterface

// File: hw/rtl/dtnp_char_stage.sv
// ----------------------------------------------------------------------------
// dtnp_char_stage: input register
// Registers each character transfer before it reaches the parse logic.
// ----------------------------------------------------------------------------
module dtnp_char_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    dtnp_char_if.sink            char_ch,
    output logic                 item_valid,
    input  logic                 item_ready,
    output dtnp_pkg::char_item_t item
);

    logic                 valid_reg;
    dtnp_pkg::char_item_t item_reg;
    logic                 load;

    assign char_ch.ready = !valid_reg || item_ready;
    assign load          = char_ch.valid && char_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (char_ch.ready)
        begin
            valid_reg <= char_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.text_char  <= char_ch.text_char;
            item_reg.string_end <= char_ch.string_end;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: hw/rtl/dtnp_parse_core.sv
// ----------------------------------------------------------------------------
// dtnp_parse_core: per-character parse state
// Folds one character per cycle into the running parse while the raw result is
// not held downstream, and registers the finished parse when the number ends.
// ----------------------------------------------------------------------------
module dtnp_parse_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  real_mode,
    input  logic                  gobble_mode,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  dtnp_pkg::char_item_t  item,
    output logic                  raw_valid,
    input  logic                  raw_ready,
    output dtnp_pkg::raw_result_t raw
);

    logic [dtnp_pkg::MANT_WIDTH-1:0] acc_reg, acc_next;
    logic [dtnp_pkg::FRAC_WIDTH-1:0] frac_reg, frac_next;
    logic                            neg_reg, neg_next;
    logic                            point_reg, point_next;
    logic                            seen_reg, seen_next;
    logic                            bad_reg, bad_next;
    dtnp_pkg::count_t                pos_reg, pos_next;
    logic                            raw_valid_reg;
    dtnp_pkg::raw_result_t           raw_reg, raw_next;

    logic                            take;
    logic                            finish;
    logic                            is_digit;
    logic [3:0]                      digit;
    logic [dtnp_pkg::PROD_WIDTH-1:0] acc_wide;
    logic [dtnp_pkg::PROD_WIDTH-1:0] prod;
    logic                            prod_ovf;

    assign item_ready = !raw_valid_reg || raw_ready;
    assign take       = item_valid && item_ready;

    // acc * 10 + digit as shift-and-add; anything at or above bit 63 overflows
    assign is_digit = (item.text_char >= dtnp_pkg::CHAR_ZERO) &&
                      (item.text_char <= dtnp_pkg::CHAR_NINE);
    assign digit    = 4'(item.text_char - dtnp_pkg::CHAR_ZERO);
    assign acc_wide = {4'b0, acc_reg};
    assign prod     = (acc_wide << 3) + (acc_wide << 1) +
                      {{(dtnp_pkg::PROD_WIDTH-4){1'b0}}, digit};
    assign prod_ovf = |prod[dtnp_pkg::PROD_WIDTH-1:dtnp_pkg::MANT_WIDTH-1];

    always_comb
    begin
        acc_next   = acc_reg;
        frac_next  = frac_reg;
        neg_next   = neg_reg;
        point_next = point_reg;
        seen_next  = seen_reg;
        bad_next   = bad_reg;
        finish     = 1'b0;
        pos_next   = (pos_reg != dtnp_pkg::COUNT_MAX) ? pos_reg + 1'b1 : pos_reg;

        if (is_digit)
        begin
            seen_next = 1'b1;
            if (!real_mode)
            begin
                acc_next = {32'b0, prod[31:0]};
            end
            else if (!point_reg)
            begin
                acc_next = prod_ovf ? dtnp_pkg::MANT_LIMIT
                                    : prod[dtnp_pkg::MANT_WIDTH-1:0];
            end
            else if ((frac_reg < dtnp_pkg::MAX_FRACTION_DIGITS) && !prod_ovf)
            begin
                acc_next  = prod[dtnp_pkg::MANT_WIDTH-1:0];
                frac_next = frac_reg + 1'b1;
            end
        end
        else if (real_mode && !point_reg && (item.text_char == dtnp_pkg::CHAR_DOT))
        begin
            point_next = 1'b1;
        end
        else if ((pos_reg == '0) && (item.text_char == dtnp_pkg::CHAR_MINUS))
        begin
            neg_next = 1'b1;
        end
        else if (gobble_mode)
        begin
            finish = 1'b1;
        end
        else
        begin
            bad_next = 1'b1;
        end

        if (item.string_end)
        begin
            finish = 1'b1;
        end

        raw_next.parse_ok        = seen_next && !bad_next;
        raw_next.real_mode       = real_mode;
        raw_next.is_negative     = neg_next;
        raw_next.magnitude       = raw_next.parse_ok ? acc_next : '0;
        raw_next.fraction_digits = raw_next.parse_ok ? frac_next : '0;
        raw_next.chars_consumed  = pos_next;
        raw_next.hit_string_end  = item.string_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            frac_reg      <= '0;
            neg_reg       <= 1'b0;
            point_reg     <= 1'b0;
            seen_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            pos_reg       <= '0;
            raw_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                raw_valid_reg <= take && finish;
            end
            if (take)
            begin
                if (finish)
                begin
                    // start the next parse from scratch
                    acc_reg   <= '0;
                    frac_reg  <= '0;
                    neg_reg   <= 1'b0;
                    point_reg <= 1'b0;
                    seen_reg  <= 1'b0;
                    bad_reg   <= 1'b0;
                    pos_reg   <= '0;
                end
                else
                begin
                    acc_reg   <= acc_next;
                    frac_reg  <= frac_next;
                    neg_reg   <= neg_next;
                    point_reg <= point_next;
                    seen_reg  <= seen_next;
                    bad_reg   <= bad_next;
                    pos_reg   <= pos_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && finish)
        begin
            raw_reg <= raw_next;
        end
    end

    assign raw_valid = raw_valid_reg;
    assign raw       = raw_reg;

endmodule

// File: hw/rtl/dtnp_result_stage.sv
// ----------------------------------------------------------------------------
// dtnp_result_stage: output register
// Applies the sign and the integer-mode 32-bit wrap, then holds the result
// for the downstream transfer.
// ----------------------------------------------------------------------------
module dtnp_result_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  raw_valid,
    output logic                  raw_ready,
    input  dtnp_pkg::raw_result_t raw,
    dtnp_result_if.source         result_ch
);

    logic                            valid_reg;
    logic                            ok_reg;
    logic signed [63:0]              mant_reg, mant_next;
    logic [dtnp_pkg::FRAC_WIDTH-1:0] frac_reg;
    logic [15:0]                     count_reg;
    logic                            end_reg;
    logic [dtnp_pkg::MANT_WIDTH-1:0] signed_mag;

    assign raw_ready = !valid_reg || result_ch.ready;

    always_comb
    begin
        signed_mag = raw.is_negative ? ('0 - raw.magnitude) : raw.magnitude;
        if (raw.real_mode)
        begin
            mant_next = signed_mag;
        end
        else
        begin
            mant_next = {{32{signed_mag[31]}}, signed_mag[31:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (raw_ready)
        begin
            valid_reg <= raw_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw_valid && raw_ready)
        begin
            ok_reg    <= raw.parse_ok;
            mant_reg  <= mant_next;
            frac_reg  <= raw.fraction_digits;
            count_reg <= 16'(raw.chars_consumed);
            end_reg   <= raw.hit_string_end;
        end
    end

    assign result_ch.valid           = valid_reg;
    assign result_ch.parse_ok        = ok_reg;
    assign result_ch.mantissa        = mant_reg;
    assign result_ch.fraction_digits = frac_reg;
    assign result_ch.chars_consumed  = count_reg;
    assign result_ch.hit_string_end  = end_reg;

endmodule

// File: hw/rtl/decimal_text_number_parser.sv
// ----------------------------------------------------------------------------
// decimal_text_number_parser: streaming ASCII decimal number parser
// Parses signed integer or real decimal numbers from a character stream and
// emits mantissa, fraction digit count and consumed-character count.
//
//   channel    dir   payload                                    rate
//   char_ch    in    text_char[8], string_end                   1 char / cycle, unless stalled
//   result_ch  out   parse_ok, mantissa[64] signed,             <= 1 per char
//                    fraction_digits[5], chars_consumed[16],
//                    hit_string_end
//   cfg_*      in    index 0 real_mode, index 1 gobble_mode     write only
//
// One character transfer per cycle sustained while result_ch is not stalled.
// A result becomes valid once the character that ends the number has passed
// each register in order: its transfer loads the input register, the parse
// state update (one multiply-by-ten shift-add and overflow check) loads the
// raw result, and the sign-handled result then loads the output register.
// Reset clears the parse state, the mode registers and all valid flags.
// A stall on result_ch backs up through each register stage in turn; every
// stage still takes a new transfer while its own content drains.
// ----------------------------------------------------------------------------
module decimal_text_number_parser (
    input  logic                                 clk,
    input  logic                                 rst_n,
    dtnp_char_if.sink                            char_ch,
    dtnp_result_if.source                        result_ch,
    input  logic                                 cfg_wr_en,
    input  logic [dtnp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [dtnp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    // Mode registers
    logic real_mode_reg;
    logic gobble_mode_reg;

    // Input register to parse core
    logic                  item_valid;
    logic                  item_ready;
    dtnp_pkg::char_item_t  item;

    // Parse core to output register
    logic                  raw_valid;
    logic                  raw_ready;
    dtnp_pkg::raw_result_t raw;

    // Configuration writes; user must only issue them while parser is idle, unenforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_mode_reg   <= 1'b0;
            gobble_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (dtnp_pkg::cfg_reg_t'(cfg_index))
                dtnp_pkg::REG_REAL_MODE:   real_mode_reg   <= cfg_data[0];
                dtnp_pkg::REG_GOBBLE_MODE: gobble_mode_reg <= cfg_data[0];
                default:                   real_mode_reg   <= real_mode_reg;
            endcase
        end
    end

    // Register each incoming character
    dtnp_char_stage u_char_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_ch    (char_ch),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // Advance the running parse; a finished number drops into the raw result
    dtnp_parse_core u_parse_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .real_mode   (real_mode_reg),
        .gobble_mode (gobble_mode_reg),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .raw_valid   (raw_valid),
        .raw_ready   (raw_ready),
        .raw         (raw)
    );

    // Sign the magnitude, wrap integer results to 32 bits, hold for transfer
    dtnp_result_stage u_result_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_ready (raw_ready),
        .raw       (raw),
        .result_ch (result_ch)
    );

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the decimal text number parser
// Feeds ASCII characters over the character channel and predicts every parse
// result in a small scoreboard class that tracks the parse state and both
// mode registers. Checks each result transfer against the oldest prediction.
// Runs a directed set of corner strings first, then random numbers, noise and
// delimiters under all mode settings and several idle patterns.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;      // well beyond the time a number takes through the three register stages
    localparam int PHASE_CHARS   = 84;
    localparam int STALL_CYCLES  = 90;

    // One parse result as seen on the result channel
    typedef struct packed {
        logic        ok;
        logic [63:0] mant;
        logic [4:0]  frac;
        logic [15:0] consumed;
        logic        hit_end;
    } parsed_number_t;

    // Tracks the parse state, predicts each result and checks what comes out
    class number_tracker;
        bit             real_mode;
        bit             gobble_mode;
        bit [63:0]      accum;
        bit [4:0]       frac_count;
        bit             negative;
        bit             point_seen;
        bit             digit_seen;
        bit             bad_char;
        bit [15:0]      position;
        parsed_number_t expected_numbers[$];
        int unsigned    chars_taken;
        int unsigned    numbers_checked;
        int unsigned    mismatches;

        function void note_failure(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        // Advance the parse by one accepted character
        function void note_char(logic [7:0] c, bit last);
            bit             first;
            bit             finish;
            bit [63:0]      d;
            bit [63:0]      headroom;
            parsed_number_t r;
            first  = (position == 0);
            finish = 1'b0;
            chars_taken++;
            if (position != dtnp_pkg::COUNT_MAX)
                position++;
            if (c >= dtnp_pkg::CHAR_ZERO && c <= dtnp_pkg::CHAR_NINE) begin
                d          = 64'(c - dtnp_pkg::CHAR_ZERO);
                headroom   = (dtnp_pkg::MANT_LIMIT - d) / 10;
                digit_seen = 1'b1;
                if (!real_mode)
                    accum = (accum * 10 + d) & 64'hFFFF_FFFF;
                else if (!point_seen)
                    accum = (accum > headroom) ? dtnp_pkg::MANT_LIMIT : accum * 10 + d;
                else if (frac_count < dtnp_pkg::MAX_FRACTION_DIGITS && accum <= headroom) begin
                    accum = accum * 10 + d;
                    frac_count++;
                end
            end
            else if (real_mode && !point_seen && c == dtnp_pkg::CHAR_DOT)
                point_seen = 1'b1;
            else if (first && c == dtnp_pkg::CHAR_MINUS)
                negative = 1'b1;
            else if (gobble_mode)
                finish = 1'b1;
            else
                bad_char = 1'b1;
            if (last)
                finish = 1'b1;
            if (!finish)
                return;
            r.ok   = digit_seen && !bad_char;
            r.mant = '0;
            r.frac = '0;
            if (r.ok) begin
                r.mant = negative ? -accum : accum;
                if (!real_mode)
                    r.mant = {{32{r.mant[31]}}, r.mant[31:0]};
                r.frac = frac_count;
            end
            r.consumed = position;
            r.hit_end  = last;
            expected_numbers.push_back(r);
            accum      = '0;
            frac_count = '0;
            negative   = 1'b0;
            point_seen = 1'b0;
            digit_seen = 1'b0;
            bad_char   = 1'b0;
            position   = '0;
        endfunction

        function void check_number(parsed_number_t got);
            parsed_number_t want;
            if (expected_numbers.size() == 0) begin
                note_failure($sformatf("unexpected result ok=%0b mantissa=%0d chars=%0d",
                                       got.ok, $signed(got.mant), got.consumed));
                return;
            end
            want = expected_numbers.pop_front();
            numbers_checked++;
            if (got !== want)
                note_failure($sformatf({"result %0d: expected ok=%0b mant=%0d frac=%0d ",
                                        "chars=%0d end=%0b, got ok=%0b mant=%0d frac=%0d ",
                                        "chars=%0d end=%0b"},
                                       numbers_checked, want.ok, $signed(want.mant),
                                       want.frac, want.consumed, want.hit_end, got.ok,
                                       $signed(got.mant), got.frac, got.consumed,
                                       got.hit_end));
        endfunction
    endclass

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 cfg_wr_en;
    logic [dtnp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [dtnp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

    dtnp_char_if   char_ch ();
    dtnp_result_if result_ch ();

    number_tracker tracker = new();

    int unsigned send_idle_pct  = 17;
    int unsigned recv_idle_pct  = 47;
    bit          long_stall_req = 1'b0;
    int unsigned stall_left     = 0;
    int unsigned cycle_count    = 0;

    // Characters of the next token, with their end-of-string marks
    logic [7:0]  tok_chars[$];
    bit          tok_ends[$];

    decimal_text_number_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_ch   (char_ch),
        .result_ch (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver side: random ready, or a long hold-off when one is requested.
    // The request is raised at a falling edge and taken here at a rising one.
    always @(posedge clk)
    begin
        if (long_stall_req)
        begin
            stall_left     = STALL_CYCLES;
            long_stall_req = 1'b0;
        end
        if (stall_left != 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check results at the falling edge: valid, ready and payload are stable
    // there and the transfer completes at the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready)
            tracker.check_number(parsed_number_t'({result_ch.parse_ok, result_ch.mantissa,
                                                   result_ch.fraction_digits,
                                                   result_ch.chars_consumed,
                                                   result_ch.hit_string_end}));
    end

    // Offer one character, idling first at random, and hold it until the
    // transfer. Ready is sampled at the falling edge where it is stable.
    task automatic push_char(input logic [7:0] c, input bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_ch.valid <= 1'b0;
            @(posedge clk);
        end
        char_ch.valid      <= 1'b1;
        char_ch.text_char  <= c;
        char_ch.string_end <= last;
        @(negedge clk);
        while (!char_ch.ready)
            @(negedge clk);
        @(posedge clk);
        tracker.note_char(c, last);
    endtask

    task automatic send_text(input string s, input bit end_last);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], end_last && (i == s.len() - 1));
    endtask

    // Drop valid, wait for every predicted result, then let any partial
    // parse settle through the pipeline
    task automatic drain();
        char_ch.valid <= 1'b0;
        while (tracker.expected_numbers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both mode registers while the block is idle
    task automatic apply_modes(input bit real_v, input bit gobble_v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= dtnp_pkg::REG_REAL_MODE;
        cfg_data  <= real_v;
        @(posedge clk);
        tracker.real_mode = real_v;
        cfg_index <= dtnp_pkg::REG_GOBBLE_MODE;
        cfg_data  <= gobble_v;
        @(posedge clk);
        tracker.gobble_mode = gobble_v;
        cfg_wr_en <= 1'b0;
    endtask

    // Build one token: mostly a well-formed number with random digits,
    // sometimes long enough to overflow, ended to suit the mode; else noise
    task automatic compose_token();
        int unsigned pick;
        int unsigned n_int;
        int unsigned n_frac;
        int unsigned n_noise;
        tok_chars.delete();
        tok_ends.delete();
        pick = $urandom_range(99);
        if (pick < 78)
        begin
            if ($urandom_range(3) == 0)
                tok_chars.push_back(dtnp_pkg::CHAR_MINUS);
            pick  = $urandom_range(19);
            n_int = (pick == 0) ? 0 : (pick < 3) ? $urandom_range(22, 10) : $urandom_range(6, 1);
            repeat (n_int) tok_chars.push_back(8'(dtnp_pkg::CHAR_ZERO + $urandom_range(9)));
            if (tracker.real_mode && $urandom_range(1))
            begin
                tok_chars.push_back(dtnp_pkg::CHAR_DOT);
                pick   = $urandom_range(9);
                n_frac = (pick < 2) ? $urandom_range(22, 15) : $urandom_range(5);
                repeat (n_frac) tok_chars.push_back(8'(dtnp_pkg::CHAR_ZERO + $urandom_range(9)));
            end
            if (tracker.gobble_mode)
            begin
                // delimiter: blank, comma, plus, a point, a minus or any byte
                if ($urandom_range(2) != 0)
                    case ($urandom_range(5))
                        0:       tok_chars.push_back(" ");
                        1:       tok_chars.push_back(",");
                        2:       tok_chars.push_back("+");
                        3:       tok_chars.push_back(dtnp_pkg::CHAR_DOT);
                        4:       tok_chars.push_back(dtnp_pkg::CHAR_MINUS);
                        default: tok_chars.push_back(8'($urandom_range(255)));
                    endcase
            end
            else if ($urandom_range(5) == 0 && tok_chars.size() != 0)
                tok_chars[$urandom_range(tok_chars.size() - 1)] = 8'($urandom_range(255));
            if (tok_chars.size() == 0)
                tok_chars.push_back(8'(dtnp_pkg::CHAR_ZERO + $urandom_range(9)));
            foreach (tok_chars[i])
                tok_ends.push_back(1'b0);
            // strict parses run to the end of the string; gobble ones mostly stop early
            tok_ends[tok_ends.size() - 1] = !tracker.gobble_mode || ($urandom_range(2) == 0);
        end
        else
        begin
            n_noise = $urandom_range(4, 1);
            repeat (n_noise)
            begin
                tok_chars.push_back(8'($urandom_range(255)));
                tok_ends.push_back($urandom_range(3) == 0);
            end
        end
    endtask

    // One random phase under fixed modes and idle rates
    task automatic run_phase(input bit real_v, input bit gobble_v, input int unsigned s_pct,
                             input int unsigned r_pct, input bit hold_output,
                             input bit pause_midway);
        int unsigned goal;
        bit          paused;
        apply_modes(real_v, gobble_v);
        @(negedge clk);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        if (hold_output)
            long_stall_req = 1'b1;
        @(posedge clk);
        goal   = tracker.chars_taken + PHASE_CHARS;
        paused = 1'b0;
        while (tracker.chars_taken < goal)
        begin
            compose_token();
            foreach (tok_chars[i])
                push_char(tok_chars[i], tok_ends[i]);
            // stop sending halfway until the output side has caught up
            if (pause_midway && !paused && tracker.chars_taken + PHASE_CHARS / 2 >= goal)
            begin
                drain();
                paused = 1'b1;
            end
        end
    endtask

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 tracker.expected_numbers.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        char_ch.valid      = 1'b0;
        char_ch.text_char  = '0;
        char_ch.string_end = 1'b0;
        result_ch.ready    = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = dtnp_pkg::REG_REAL_MODE;
        cfg_data           = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: strict integer mode
        apply_modes(1'b0, 1'b0);
        send_text("-", 1'b1);             // minus alone is invalid
        push_char(8'h00, 1'b1);           // illegal character in strict mode
        send_text("-5000000000", 1'b1);   // wraps modulo 2^32

        // Directed: gobble real mode
        apply_modes(1'b1, 1'b1);
        send_text("1.2.", 1'b0);          // second point ends the parse
        push_char(8'hFF, 1'b1);           // delimiter on the last character
        send_text(".", 1'b1);             // point alone is invalid
        send_text("-1.2", 1'b0);          // left open across a mode change
        apply_modes(1'b0, 1'b1);
        send_text("5", 1'b1);             // finished in integer mode

        // Random: sender light/receiver heavy, then swapped, then no idling
        run_phase(1'b1, 1'b0, 17, 47, 1'b0, 1'b0);
        run_phase(1'b0, 1'b1, 17, 47, 1'b0, 1'b0);
        run_phase(1'b1, 1'b1, 47, 17, 1'b0, 1'b1);
        run_phase(1'b0, 1'b0, 47, 17, 1'b0, 1'b0);
        run_phase(1'b1, 1'b1, 0, 0, 1'b1, 1'b0);
        run_phase(1'b1, 1'b0, 0, 0, 1'b0, 1'b0);

        drain();
        if (tracker.expected_numbers.size() != 0)
            tracker.note_failure($sformatf("%0d results never arrived",
                                           tracker.expected_numbers.size()));
        $display("covered %0d characters and %0d checked results over all four mode settings",
                 tracker.chars_taken, tracker.numbers_checked);
        $display("including overflow, mid-parse mode change, long output stall, midway pause");
        if (tracker.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
